// File: design/ccrq_pkg.sv
package ccrq_pkg;

  localparam int unsigned DefMaxChannels = 1024;
  localparam int unsigned DefMaxPixels   = 65536;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned ValueW   = 16;
  localparam int unsigned PixOutW  = 16;
  localparam int unsigned ChanOutW = 11;
  localparam int unsigned InChW    = 11;
  localparam int unsigned OffsetW  = 10;
  localparam int unsigned MultW    = 15;
  localparam int unsigned ShiftW   = 6;

  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 48;

  // shifts of 31 and above always give zero for a 16x15 product
  localparam logic [ShiftW-1:0] ShiftCap = 6'd32;

  typedef enum logic [CfgAddrW-1:0] {
    REG_IN_CHANNELS    = 3'd0,
    REG_CHANNEL_OFFSET = 3'd1,
    REG_WIDE_MODE      = 3'd2,
    REG_REQUANT_ENABLE = 3'd3,
    REG_MULTIPLIER     = 3'd4,
    REG_SHIFT_AMOUNT   = 3'd5,
    REG_CLAMP_LOW      = 3'd6,
    REG_CLAMP_HIGH     = 3'd7
  } cfg_reg_t;

endpackage

// File: design/channel_concat_requantize_core.sv
// channel_concat_requantize_core
// places one branch of a channel-wise concatenation of an NHWC tensor stream.
// input stream: one element per transaction, in_tdata carries the sample and
// in_tlast marks the final element of the tensor. each element is optionally
// rescaled (multiply, round-half-up shift, clamp, truncate to 8/16 bits) and
// leaves on the output stream with its pixel index and destination channel.
// the result of an input transaction is held in the output register from the
// cycle after it. throughput: one element per cycle; the single output
// register is reloaded in the same cycle its content is taken, so the only
// stall source is the receiver. while out_tready is low and a result is held,
// in_tready drops and the held result stays unchanged.
// reset (rst_n low, synchronous): channel and pixel counters go to zero, the
// output register empties and the configuration registers take their reset
// values. the user writes configuration via cfg_wr_en/cfg_addr/cfg_wdata only
// while no element is in flight; the block itself does not enforce this.
module channel_concat_requantize_core #(
  parameter int unsigned MAX_CHANNELS = ccrq_pkg::DefMaxChannels,
  parameter int unsigned MAX_PIXELS   = ccrq_pkg::DefMaxPixels
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [ccrq_pkg::CfgAddrW-1:0]   cfg_addr,
  input  logic [ccrq_pkg::CfgDataW-1:0]   cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ccrq_pkg::InDataW-1:0]    in_tdata,   // [15:0] sample_value
  input  logic                            in_tlast,   // last_element
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [15:0] out_value, [31:16] pixel_index, [42:32] out_channel, [47:43] zero
  output logic [ccrq_pkg::OutDataW-1:0]   out_tdata
);
  import ccrq_pkg::*;

  localparam int unsigned CW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned PW  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned EW  = (CW + 1 > InChW) ? CW + 1 : InChW;
  localparam int unsigned PCW = PW + 1;

  // configuration registers
  logic [InChW-1:0]          in_channels_r;
  logic [OffsetW-1:0]        channel_offset_r;
  logic                      wide_mode_r;
  logic                      requant_enable_r;
  logic [MultW-1:0]          multiplier_r;
  logic [ShiftW-1:0]         shift_amount_r;
  logic signed [ValueW-1:0]  clamp_low_r;
  logic signed [ValueW-1:0]  clamp_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_channels_r    <= InChW'(1);
      channel_offset_r <= '0;
      wide_mode_r      <= 1'b0;
      requant_enable_r <= 1'b0;
      multiplier_r     <= '0;
      shift_amount_r   <= '0;
      clamp_low_r      <= 16'sh8000;
      clamp_high_r     <= 16'sh7FFF;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_addr))
        REG_IN_CHANNELS:    in_channels_r    <= cfg_wdata[InChW-1:0];
        REG_CHANNEL_OFFSET: channel_offset_r <= cfg_wdata[OffsetW-1:0];
        REG_WIDE_MODE:      wide_mode_r      <= cfg_wdata[0];
        REG_REQUANT_ENABLE: requant_enable_r <= cfg_wdata[0];
        REG_MULTIPLIER:     multiplier_r     <= cfg_wdata[MultW-1:0];
        REG_SHIFT_AMOUNT:   shift_amount_r   <= cfg_wdata[ShiftW-1:0];
        REG_CLAMP_LOW:      clamp_low_r      <= cfg_wdata[ValueW-1:0];
        REG_CLAMP_HIGH:     clamp_high_r     <= cfg_wdata[ValueW-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic out_valid_r;
  logic in_fire;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  // requantize datapath
  logic signed [ValueW-1:0]  sample_v;
  logic signed [31:0]        product;
  logic [ShiftW-1:0]         shift_eff;
  logic signed [33:0]        round_term;
  logic signed [33:0]        rounded;
  logic signed [33:0]        shifted;
  logic signed [33:0]        clamped;
  logic signed [ValueW-1:0]  value_nxt;

  always_comb begin
    if (wide_mode_r) begin
      sample_v = in_tdata[ValueW-1:0];
    end else begin
      sample_v = {{8{in_tdata[7]}}, in_tdata[7:0]};
    end

    product   = 32'(sample_v * $signed({1'b0, multiplier_r}));
    shift_eff = (shift_amount_r > ShiftCap) ? ShiftCap : shift_amount_r;

    if (shift_eff == '0) begin
      round_term = '0;
    end else begin
      round_term = 34'sd1 <<< (shift_eff - ShiftW'(1));
    end
    rounded = 34'(product) + round_term;
    shifted = rounded >>> shift_eff;

    // low bound first, then high bound, so crossed bounds give the high one
    clamped = shifted;
    if (clamped < 34'(clamp_low_r)) begin
      clamped = 34'(clamp_low_r);
    end
    if (clamped > 34'(clamp_high_r)) begin
      clamped = 34'(clamp_high_r);
    end

    if (!requant_enable_r) begin
      value_nxt = sample_v;
    end else if (wide_mode_r) begin
      value_nxt = clamped[ValueW-1:0];
    end else begin
      value_nxt = {{8{clamped[7]}}, clamped[7:0]};
    end
  end

  // position counters
  logic [CW-1:0]  chan_cnt_r;
  logic [CW-1:0]  chan_cnt_nxt;
  logic [PW-1:0]  pix_cnt_r;
  logic [PW-1:0]  pix_cnt_nxt;
  logic [EW-1:0]  eff_channels;
  logic [EW-1:0]  chan_plus1;
  logic [PCW-1:0] pix_plus1;

  always_comb begin
    if (in_channels_r == '0) begin
      eff_channels = EW'(1);
    end else if (EW'(in_channels_r) > EW'(MAX_CHANNELS)) begin
      eff_channels = EW'(MAX_CHANNELS);
    end else begin
      eff_channels = EW'(in_channels_r);
    end

    chan_plus1 = EW'(chan_cnt_r) + EW'(1);
    pix_plus1  = PCW'(pix_cnt_r) + PCW'(1);

    chan_cnt_nxt = chan_cnt_r;
    pix_cnt_nxt  = pix_cnt_r;
    if (in_tlast) begin
      chan_cnt_nxt = '0;
      pix_cnt_nxt  = '0;
    end else if (chan_plus1 >= eff_channels) begin
      chan_cnt_nxt = '0;
      if (pix_plus1 >= PCW'(MAX_PIXELS)) begin
        pix_cnt_nxt = '0;
      end else begin
        pix_cnt_nxt = pix_plus1[PW-1:0];
      end
    end else begin
      chan_cnt_nxt = chan_plus1[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_cnt_r <= '0;
      pix_cnt_r  <= '0;
    end else if (in_fire) begin
      chan_cnt_r <= chan_cnt_nxt;
      pix_cnt_r  <= pix_cnt_nxt;
    end
  end

  // result fields
  logic [PW+PixOutW-1:0]    pix_wide;
  logic [CW+ChanOutW-1:0]   chan_sum;
  logic [OutDataW-1:0]      out_data_nxt;
  logic [OutDataW-1:0]      out_data_r;

  always_comb begin
    pix_wide     = (PW + PixOutW)'(pix_cnt_r);
    chan_sum     = (CW + ChanOutW)'(channel_offset_r) + (CW + ChanOutW)'(chan_cnt_r);
    out_data_nxt = '0;
    out_data_nxt[ValueW-1:0]                    = value_nxt;
    out_data_nxt[ValueW+PixOutW-1:ValueW]       = pix_wide[PixOutW-1:0];
    out_data_nxt[ValueW+PixOutW+ChanOutW-1:ValueW+PixOutW] = chan_sum[ChanOutW-1:0];
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tdata = out_data_r;

endmodule
